/* src/tq_pkg.sv */
// Shared types and codes for the throttled order queue.
// Used by the table cell and the top level.
package tq_pkg;

  // Index field width, wide enough for the deepest supported table
  localparam int IDX_W = 12;

  typedef enum logic [2:0] {
    ACT_NEW    = 3'd0,
    ACT_MODIFY = 3'd1,
    ACT_CANCEL = 3'd2,
    ACT_REPLY  = 3'd3,
    ACT_TICK   = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    OUT_QUEUED       = 4'd0,
    OUT_MODIFIED     = 4'd1,
    OUT_CANCELLED    = 4'd2,
    OUT_ALREADY_SENT = 4'd3,
    OUT_NOT_FOUND    = 4'd4,
    OUT_FULL         = 4'd5,
    OUT_DUPLICATE    = 4'd6,
    OUT_SENT         = 4'd7,
    OUT_IDLE         = 4'd8,
    OUT_FREED        = 4'd9
  } outcome_t;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_MODIFY,
    OP_FREE,
    OP_SEND
  } slot_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  localparam logic [2:0] REG_SENDS = 3'd0;
  localparam logic [2:0] REG_TICKS = 3'd4;

  // Search token that walks the cell chain
  typedef struct packed {
    logic             active;
    logic [31:0]      key;
    logic [31:0]      arr;
    logic             found;
    logic [IDX_W-1:0] found_idx;
    logic             found_sent;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             best_found;
    logic [IDX_W-1:0] best_idx;
    logic [31:0]      best_dist;
    logic [31:0]      best_key;
    logic [63:0]      best_data;
  } token_t;

  // Update command broadcast to all cells
  typedef struct packed {
    logic             en;
    slot_op_t         op;
    logic [IDX_W-1:0] idx;
    logic [31:0]      key;
    logic [63:0]      data;
    logic [31:0]      age;
  } slot_cmd_t;

endpackage

/* src/tq_in_if.sv */
// Order input channel: valid/ready handshake with the order fields.
// Depends on nothing.
interface tq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] order_id;
  logic [63:0] order_data;

  modport source (output valid, output action, output order_id, output order_data,
                  input ready);
  modport sink (input valid, input action, input order_id, input order_data,
                output ready);
endinterface

/* src/tq_out_if.sv */
// Result channel: valid/ready handshake with the result fields.
// CW sets the width of the pending count.
interface tq_out_if #(parameter int CW = 7);
  logic          valid;
  logic          ready;
  logic [3:0]    outcome;
  logic [31:0]   out_id;
  logic [63:0]   out_data;
  logic [CW-1:0] pending_count;

  modport source (output valid, output outcome, output out_id, output out_data,
                  output pending_count, input ready);
  modport sink (input valid, input outcome, input out_id, input out_data,
                input pending_count, output ready);
endinterface

/* src/throttled_order_queue.sv */
// Throttled order queue: a table of orders kept in arrival order, released
// to the exchange at most sends_per_window times per window of ticks.
//
// Channels: orders (sink) takes action, order_id and order_data; results
// (source) gives one item per order: outcome, out_id, out_data and
// pending_count. A transfer happens when valid and ready are both high.
// The APB port writes sends_per_window at 0x0 and ticks_per_window at 0x4.
//
// Each order launches a search token at the chain head; the token passes
// the chain of slot cells, then the table is updated and the result loaded.
// One order is in work at a time; the next is taken while the result
// register still waits. A stalled receiver holds the result and, once the
// next order's search ends, holds that order until the register frees.
// Reset empties the table, clears counters and restores 100 sends per
// 1000 ticks.
// Depends on tq_pkg, tq_in_if, tq_out_if and tq_cell.
module throttled_order_queue #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  tq_in_if.sink       orders,
  tq_out_if.source    results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tq_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_t      state, state_next;
  logic [15:0] sends_per_window;
  logic [31:0] ticks_per_window;
  logic [31:0] arrival_counter, arrival_counter_next;
  logic [CW-1:0] waiting_total, waiting_total_next;
  logic [15:0] released_in_window, released_in_window_next;
  logic [31:0] window_elapsed, window_elapsed_next;

  logic [2:0]  cur_action;
  logic [31:0] cur_id;
  logic [63:0] cur_data;

  logic          out_valid;
  logic [3:0]    out_outcome, outcome_next;
  logic [31:0]   out_id, id_next;
  logic [63:0]   out_data, data_next;

  token_t      tok [0:TABLE_DEPTH];
  token_t      tail;
  token_t      res;
  slot_cmd_t   cmd;
  logic        accept;
  logic        finish;
  logic [15:0] rel_base;
  logic [31:0] el_base;

  // Configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      sends_per_window <= 16'd100;
      ticks_per_window <= 32'd1000;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_TICKS[2]) begin
        ticks_per_window <= pwdata;
      end else begin
        sends_per_window <= pwdata[15:0];
      end
    end
  end
  assign prdata = (paddr[2] == REG_SENDS[2]) ? {16'd0, sends_per_window} : ticks_per_window;

  // Launch the search token at the chain head
  assign accept = orders.valid && orders.ready;
  always_comb begin
    tok[0]        = '0;
    tok[0].active = accept;
    tok[0].key    = orders.order_id;
    tok[0].arr    = arrival_counter;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    tq_cell #(.IDX(g)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (tok[g]),
      .tok_out(tok[g+1]),
      .cmd    (cmd)
    );
  end
  assign tail = tok[TABLE_DEPTH];

  // Sequence one order and decide its outcome
  always_comb begin
    state_next              = state;
    orders.ready            = (state == ST_IDLE);
    finish                  = 1'b0;
    cmd                     = '0;
    cmd.key                 = cur_id;
    cmd.data                = cur_data;
    cmd.age                 = arrival_counter;
    arrival_counter_next    = arrival_counter;
    waiting_total_next      = waiting_total;
    released_in_window_next = released_in_window;
    window_elapsed_next     = window_elapsed;
    outcome_next            = OUT_IDLE;
    id_next                 = cur_id;
    data_next               = '0;
    rel_base                = released_in_window;
    el_base                 = window_elapsed;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail.active) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || results.ready) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
          case (cur_action)
            ACT_NEW, ACT_MODIFY: begin
              if (res.found && cur_action == ACT_NEW) begin
                outcome_next = OUT_DUPLICATE;
              end else if (res.found && res.found_sent) begin
                outcome_next = OUT_ALREADY_SENT;
              end else if (res.found) begin
                cmd.en       = 1'b1;
                cmd.op       = OP_MODIFY;
                cmd.idx      = res.found_idx;
                outcome_next = OUT_MODIFIED;
              end else if (res.free_found) begin
                cmd.en               = 1'b1;
                cmd.op               = OP_INSERT;
                cmd.idx              = res.free_idx;
                arrival_counter_next = arrival_counter + 32'd1;
                waiting_total_next   = waiting_total + CW'(1);
                outcome_next         = OUT_QUEUED;
              end else begin
                outcome_next = OUT_FULL;
              end
            end
            ACT_CANCEL, ACT_REPLY: begin
              if (!res.found) begin
                outcome_next = OUT_NOT_FOUND;
              end else if (res.found_sent && cur_action == ACT_CANCEL) begin
                outcome_next = OUT_ALREADY_SENT;
              end else begin
                cmd.en  = 1'b1;
                cmd.op  = OP_FREE;
                cmd.idx = res.found_idx;
                if (!res.found_sent && waiting_total != '0) begin
                  waiting_total_next = waiting_total - CW'(1);
                end
                outcome_next = (cur_action == ACT_CANCEL) ? OUT_CANCELLED : OUT_FREED;
              end
            end
            ACT_TICK: begin
              if (window_elapsed >= ticks_per_window) begin
                rel_base = '0;
                el_base  = '0;
              end
              id_next = '0;
              released_in_window_next = rel_base;
              if (rel_base < sends_per_window && res.best_found) begin
                cmd.en  = 1'b1;
                cmd.op  = OP_SEND;
                cmd.idx = res.best_idx;
                if (waiting_total != '0) begin
                  waiting_total_next = waiting_total - CW'(1);
                end
                released_in_window_next = rel_base + 16'd1;
                outcome_next = OUT_SENT;
                id_next      = res.best_key;
                data_next    = res.best_data;
              end
              window_elapsed_next = el_base + 32'd1;
            end
            default: begin
              id_next = '0;
            end
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state, counters, the latched order, the finished search token and the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      arrival_counter    <= '0;
      waiting_total      <= '0;
      released_in_window <= '0;
      window_elapsed     <= '0;
      out_valid          <= 1'b0;
    end else begin
      state              <= state_next;
      arrival_counter    <= arrival_counter_next;
      waiting_total      <= waiting_total_next;
      released_in_window <= released_in_window_next;
      window_elapsed     <= window_elapsed_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      cur_action <= orders.action;
      cur_id     <= orders.order_id;
      cur_data   <= orders.order_data;
    end
    if (state == ST_SCAN && tail.active) begin
      res <= tail;
    end
    if (finish) begin
      out_outcome <= outcome_next;
      out_id      <= id_next;
      out_data    <= data_next;
    end
  end

  // Drive the result channel
  assign results.valid         = out_valid;
  assign results.outcome       = out_outcome;
  assign results.out_id        = out_id;
  assign results.out_data      = out_data;
  assign results.pending_count = waiting_total;

  // Checks
  a_tok_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    tail.active |-> state == ST_SCAN)
    else $error("search token left the chain outside a scan");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SCAN)
    else $error("accepted order did not start a scan");
  a_waiting_bound: assert property (@(posedge clk) disable iff (rst)
    waiting_total <= DEPTH_C)
    else $error("waiting count exceeds table depth");
  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid && state == ST_IDLE)
    else $error("finished order did not load the result register");

endmodule

/* src/tq_cell.sv */
// One table slot: holds an order and folds its match into the passing token.
// Depends on tq_pkg.
module tq_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  tq_pkg::token_t    tok_in,
  output tq_pkg::token_t    tok_out,
  input  tq_pkg::slot_cmd_t cmd
);
  import tq_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic        valid;
  logic        sent;
  logic [31:0] key;
  logic [63:0] payload;
  logic [31:0] age;
  token_t      tok_next;
  logic [31:0] span;

  // Fold this slot into the token
  always_comb begin
    tok_next = tok_in;
    span = tok_in.arr - age;
    if (valid && key == tok_in.key && !tok_in.found) begin
      tok_next.found      = 1'b1;
      tok_next.found_idx  = MY_IDX;
      tok_next.found_sent = sent;
    end
    if (!valid && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = MY_IDX;
    end
    if (valid && !sent && (!tok_in.best_found || span > tok_in.best_dist)) begin
      tok_next.best_found = 1'b1;
      tok_next.best_idx   = MY_IDX;
      tok_next.best_dist  = span;
      tok_next.best_key   = key;
      tok_next.best_data  = payload;
    end
  end

  // Advance the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_in.active;
    end
    tok_out.key        <= tok_next.key;
    tok_out.arr        <= tok_next.arr;
    tok_out.found      <= tok_next.found;
    tok_out.found_idx  <= tok_next.found_idx;
    tok_out.found_sent <= tok_next.found_sent;
    tok_out.free_found <= tok_next.free_found;
    tok_out.free_idx   <= tok_next.free_idx;
    tok_out.best_found <= tok_next.best_found;
    tok_out.best_idx   <= tok_next.best_idx;
    tok_out.best_dist  <= tok_next.best_dist;
    tok_out.best_key   <= tok_next.best_key;
    tok_out.best_data  <= tok_next.best_data;
  end

  // Apply slot updates addressed to this cell
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      sent  <= 1'b0;
    end else if (cmd.en && cmd.idx == MY_IDX) begin
      case (cmd.op)
        OP_INSERT: begin
          valid <= 1'b1;
          sent  <= 1'b0;
        end
        OP_FREE: begin
          valid <= 1'b0;
          sent  <= 1'b0;
        end
        OP_SEND: begin
          sent <= 1'b1;
        end
        default: begin
          valid <= valid;
        end
      endcase
    end
    if (cmd.en && cmd.idx == MY_IDX) begin
      if (cmd.op == OP_INSERT) begin
        key     <= cmd.key;
        payload <= cmd.data;
        age     <= cmd.age;
      end else if (cmd.op == OP_MODIFY) begin
        payload <= cmd.data;
      end
    end
  end

endmodule
